// ----- src/zrd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ZIP record deframer package
// Shared widths, codes, signatures and the result record type.
// ----------------------------------------------------------------------------
package zrd_pkg;

   localparam int OFF_W = 33;   // record offset and total record length
   localparam int BND_W = 18;   // fixed part plus name and extra lengths

   // record kinds
   localparam logic [1:0] KIND_LOCAL   = 2'd0;
   localparam logic [1:0] KIND_CENTRAL = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   // byte regions
   localparam logic [2:0] REGION_HEADER  = 3'd0;
   localparam logic [2:0] REGION_NAME    = 3'd1;
   localparam logic [2:0] REGION_EXTRA   = 3'd2;
   localparam logic [2:0] REGION_DATA    = 3'd3;
   localparam logic [2:0] REGION_COMMENT = 3'd4;
   localparam logic [2:0] REGION_ERROR   = 3'd5;

   // archive status
   localparam logic [1:0] STATUS_RUNNING  = 2'd0;
   localparam logic [1:0] STATUS_COMPLETE = 2'd1;
   localparam logic [1:0] STATUS_BAD_SIG  = 2'd2;
   localparam logic [1:0] STATUS_TRUNC    = 2'd3;

   // signatures as seen after four little-endian bytes
   localparam logic [31:0] SIG_LOCAL   = 32'h04034b50;
   localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
   localparam logic [31:0] SIG_END     = 32'h06054b50;

   // fixed part sizes
   localparam logic [BND_W-1:0] FIXED_LOCAL   = BND_W'(30);
   localparam logic [BND_W-1:0] FIXED_CENTRAL = BND_W'(46);
   localparam logic [BND_W-1:0] FIXED_END     = BND_W'(22);

   // offsets of the last byte of each captured field
   localparam logic [OFF_W-1:0] OFS_SIG_LAST      = OFF_W'(3);
   localparam logic [OFF_W-1:0] OFS_LOCAL_SIZE    = OFF_W'(21);
   localparam logic [OFF_W-1:0] OFS_LOCAL_NAME    = OFF_W'(27);
   localparam logic [OFF_W-1:0] OFS_LOCAL_EXTRA   = OFF_W'(29);
   localparam logic [OFF_W-1:0] OFS_CENTRAL_NAME  = OFF_W'(29);
   localparam logic [OFF_W-1:0] OFS_CENTRAL_EXTRA = OFF_W'(31);
   localparam logic [OFF_W-1:0] OFS_CENTRAL_CMT   = OFF_W'(33);
   localparam logic [OFF_W-1:0] OFS_END_CMT       = OFF_W'(21);

   typedef struct packed {
      logic [7:0] byte_out;
      logic [2:0] region;
      logic [1:0] record_kind;
      logic       record_end;
      logic [1:0] status;
   } zrd_result_type;

endpackage : zrd_pkg
`default_nettype wire

// ----- src/zrd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ZIP record deframer channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface zrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface : zrd_req_if

interface zrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic [2:0] region;
   logic [1:0] record_kind;
   logic       record_end;
   logic [1:0] status;

   modport source (output valid, output byte_out, output region, output record_kind,
                   output record_end, output status, input ready);
   modport sink   (input valid, input byte_out, input region, input record_kind,
                   input record_end, input status, output ready);
endinterface : zrd_rsp_if
`default_nettype wire

// ----- src/zrd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ZIP record parser
// Record state and the per-byte tagging logic. State advances on step.
// ----------------------------------------------------------------------------
module zrd_parser import zrd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire logic [7:0]     data_byte,
   input  wire logic           last_byte,
   output zrd_result_type      result
);

   logic [OFF_W-1:0] offset_ff,    offset_in;
   logic [1:0]       kind_ff,      kind_in;
   logic [31:0]      shift_ff,     shift_in;
   logic [BND_W-1:0] name_end_ff,  name_end_in;   // fixed + name
   logic [BND_W-1:0] extra_end_ff, extra_end_in;  // fixed + name + extra
   logic [OFF_W-1:0] total_ff,     total_in;      // whole record length
   logic             error_ff,     error_in;

   always_comb begin
      logic [31:0]      shift_new;
      logic [15:0]      hi16;
      logic [BND_W-1:0] fixed;
      logic [OFF_W-1:0] offset_next;
      logic             bad;

      shift_new    = {data_byte, shift_ff[31:8]};
      hi16         = shift_new[31:16];
      offset_next  = offset_ff + OFF_W'(1);
      fixed        = FIXED_LOCAL;
      bad          = 1'b0;

      offset_in    = offset_ff;
      kind_in      = kind_ff;
      shift_in     = shift_ff;
      name_end_in  = name_end_ff;
      extra_end_in = extra_end_ff;
      total_in     = total_ff;
      error_in     = error_ff;

      result.byte_out    = data_byte;
      result.region      = REGION_HEADER;
      result.record_kind = KIND_LOCAL;
      result.record_end  = 1'b0;
      result.status      = STATUS_RUNNING;

      if (error_ff) begin
         result.region = REGION_ERROR;
         result.status = STATUS_BAD_SIG;
      end else begin
         shift_in = shift_new;
         if (offset_ff < OFS_SIG_LAST) begin
            offset_in = offset_next;
         end else begin
            if (offset_ff == OFS_SIG_LAST) begin
               priority if (shift_new == SIG_LOCAL) begin
                  kind_in = KIND_LOCAL;
               end else if (shift_new == SIG_CENTRAL) begin
                  kind_in = KIND_CENTRAL;
               end else if (shift_new == SIG_END) begin
                  kind_in = KIND_END;
               end else begin
                  bad = 1'b1;
               end
            end

            unique case (kind_in)
               KIND_LOCAL:   fixed = FIXED_LOCAL;
               KIND_CENTRAL: fixed = FIXED_CENTRAL;
               default:      fixed = FIXED_END;
            endcase

            // start every boundary at the fixed size, then grow each one as
            // its length field completes
            if (offset_ff == OFS_SIG_LAST) begin
               name_end_in  = fixed;
               extra_end_in = fixed;
               total_in     = OFF_W'(fixed);
            end else begin
               unique case (kind_ff)
                  KIND_LOCAL: begin
                     if (offset_ff == OFS_LOCAL_SIZE) begin
                        total_in = total_ff + OFF_W'(shift_new);
                     end else if (offset_ff == OFS_LOCAL_NAME) begin
                        name_end_in  = name_end_ff + BND_W'(hi16);
                        extra_end_in = extra_end_ff + BND_W'(hi16);
                        total_in     = total_ff + OFF_W'(hi16);
                     end else if (offset_ff == OFS_LOCAL_EXTRA) begin
                        extra_end_in = extra_end_ff + BND_W'(hi16);
                        total_in     = total_ff + OFF_W'(hi16);
                     end
                  end
                  KIND_CENTRAL: begin
                     if (offset_ff == OFS_CENTRAL_NAME) begin
                        name_end_in  = name_end_ff + BND_W'(hi16);
                        extra_end_in = extra_end_ff + BND_W'(hi16);
                        total_in     = total_ff + OFF_W'(hi16);
                     end else if (offset_ff == OFS_CENTRAL_EXTRA) begin
                        extra_end_in = extra_end_ff + BND_W'(hi16);
                        total_in     = total_ff + OFF_W'(hi16);
                     end else if (offset_ff == OFS_CENTRAL_CMT) begin
                        total_in = total_ff + OFF_W'(hi16);
                     end
                  end
                  default: begin
                     if (offset_ff == OFS_END_CMT) begin
                        total_in = total_ff + OFF_W'(hi16);
                     end
                  end
               endcase
            end

            if (bad) begin
               error_in      = 1'b1;
               result.status = STATUS_BAD_SIG;
            end else begin
               result.record_kind = kind_in;
               // capture bytes all sit inside the fixed part, so the stored
               // boundaries are current wherever they decide the region
               priority if (offset_ff < OFF_W'(fixed)) begin
                  result.region = REGION_HEADER;
               end else if (offset_ff < OFF_W'(name_end_ff)) begin
                  result.region = REGION_NAME;
               end else if (offset_ff < OFF_W'(extra_end_ff)) begin
                  result.region = REGION_EXTRA;
               end else if (kind_in == KIND_LOCAL) begin
                  result.region = REGION_DATA;
               end else begin
                  result.region = REGION_COMMENT;
               end

               if (offset_next == total_in) begin
                  result.record_end = 1'b1;
                  offset_in         = '0;
               end else begin
                  offset_in = offset_next;
               end
            end
         end
      end

      // end of archive: report and start over
      if (last_byte) begin
         priority if (error_in) begin
            result.status = STATUS_BAD_SIG;
         end else if (result.record_end) begin
            result.status = STATUS_COMPLETE;
         end else begin
            result.status = STATUS_TRUNC;
         end
         offset_in    = '0;
         kind_in      = KIND_LOCAL;
         shift_in     = '0;
         name_end_in  = '0;
         extra_end_in = '0;
         total_in     = '0;
         error_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         kind_ff      <= KIND_LOCAL;
         shift_ff     <= '0;
         name_end_ff  <= '0;
         extra_end_ff <= '0;
         total_ff     <= '0;
         error_ff     <= 1'b0;
      end else if (step) begin
         offset_ff    <= offset_in;
         kind_ff      <= kind_in;
         shift_ff     <= shift_in;
         name_end_ff  <= name_end_in;
         extra_end_ff <= extra_end_in;
         total_ff     <= total_in;
         error_ff     <= error_in;
      end
   end

endmodule : zrd_parser
`default_nettype wire

// ----- src/zip_record_deframer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ZIP record deframer
// Tags each byte of a ZIP archive stream with its record kind and region.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one archive byte per request, last_byte marking the
//   final byte of the archive. rsp_chan returns one response per request:
//   the byte itself, its region, the record kind, a record end flag and the
//   archive status.
//   A request accepted into the input register is parsed and captured in
//   the response register, which then shows it on rsp_chan.
//   Throughput: one byte per cycle while rsp_chan is not stalled; the input
//   register feeds the parser, whose offset and boundary update is one 33-bit
//   add and compare, and the response register holds the result.
//   Reset clears both valid flags and all record state; the first byte after
//   reset, and the first byte after a last_byte, start a new archive.
//   When the receiver stalls, the response holds, the input register fills
//   and then req_chan.ready drops until the response is taken.
// ----------------------------------------------------------------------------
module zip_record_deframer_top import zrd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   zrd_req_if.sink    req_chan,
   zrd_rsp_if.source  rsp_chan
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   logic           out_valid_ff, out_valid_in;
   zrd_result_type out_result_ff;
   zrd_result_type result;
   logic           advance;
   logic           req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   zrd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (result)
   );

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.byte_out    = out_result_ff.byte_out;
   assign rsp_chan.region      = out_result_ff.region;
   assign rsp_chan.record_kind = out_result_ff.record_kind;
   assign rsp_chan.record_end  = out_result_ff.record_end;
   assign rsp_chan.status      = out_result_ff.status;

`ifndef NO_ASSERTIONS
   a_error_region_status : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_result_ff.region == REGION_ERROR)
      |-> (out_result_ff.status == STATUS_BAD_SIG && !out_result_ff.record_end))
      else $error("error region without bad signature status");

   a_complete_ends_record : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_result_ff.status == STATUS_COMPLETE)
      |-> out_result_ff.record_end)
      else $error("archive complete reported off a record end");

   a_stall_blocks_request : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while both stages are held");

   a_advance_fills_output : assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("parsed byte lost between stages");
`endif

endmodule : zip_record_deframer_top
`default_nettype wire
